// File: rtl/knn_pkg.sv
package knn_pkg;

  localparam int PIX_W     = 8;
  localparam int N_W       = 3;
  localparam int H_W       = 2;
  localparam int K_W       = 6;
  localparam int DIM_W     = 11;
  localparam int COORD_W   = 10;
  localparam int SUM_W     = 14;
  localparam int NUM_W     = 15;
  localparam int DEN_W     = 7;
  localparam int REM_W     = 7;
  localparam int CFG_IDX_W = 4;

  localparam int MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 4'd3;

  localparam logic [N_W-1:0]   RST_WINDOW_SIZE    = 3'd3;
  localparam logic [K_W-1:0]   RST_NEIGHBOR_COUNT = 6'd5;
  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;

  typedef struct packed {
    logic accept;
    logic rd;
    logic wr;
    logic diff;
    logic rank;
    logic div_init;
    logic div_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic interior;
  } stat_t;

endpackage

// File: rtl/knn_if.sv
interface knn_pix_if;
  import knn_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;
  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface knn_res_if;
  import knn_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;
  logic [PIX_W-1:0]   filtered_value;
  modport source (output valid, output out_col, output out_row, output filtered_value,
                  input ready);
  modport sink   (input valid, input out_col, input out_row, input filtered_value,
                  output ready);
endinterface

interface knn_cfg_if;
  import knn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/knn_ctrl.sv
module knn_ctrl #(
  parameter int MAX_WINDOW = 7,
  parameter int STEP_W     = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  knn_pkg::stat_t      stat,
  output knn_pkg::cmd_t       cmd,
  output logic [STEP_W-1:0]   step
);
  import knn_pkg::*;

  localparam int RD_N = MAX_WINDOW - 1;
  localparam int NW   = MAX_WINDOW * MAX_WINDOW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_DIST  = 4'd3;
  localparam logic [3:0] S_RANK  = 4'd4;
  localparam logic [3:0] S_RANKE = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]        st, st_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              out_valid_next;

  assign step = cnt;

  always_comb begin
    st_next        = st;
    cnt_next       = cnt;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (st)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          cnt_next   = '0;
          st_next    = (RD_N > 0) ? S_READ : S_WRITE;
        end
      end
      S_READ: begin
        cmd.rd = 1'b1;
        if (cnt == STEP_W'(RD_N - 1)) begin
          cnt_next = '0;
          st_next  = S_WRITE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_WRITE: begin
        cmd.wr  = 1'b1;
        st_next = stat.interior ? S_DIST : S_IDLE;
      end
      S_DIST: begin
        cmd.diff = 1'b1;
        cnt_next = '0;
        st_next  = S_RANK;
      end
      S_RANK: begin
        cmd.rank = 1'b1;
        if (cnt == STEP_W'(NW - 1)) begin
          cnt_next = '0;
          st_next  = S_RANKE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_RANKE: st_next = S_DINIT;
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        st_next      = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == STEP_W'(NUM_W - 1)) begin
          cnt_next = '0;
          st_next  = S_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load       = 1'b1;
          out_valid_next = 1'b1;
          st_next        = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: rtl/knn_dp.sv
module knn_dp #(
  parameter int MAX_WINDOW = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int STEP_W     = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [knn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [knn_pkg::DIM_W-1:0]      cfg_data,
  input  logic [knn_pkg::PIX_W-1:0]      pixel_in,
  input  logic                           frame_start,
  input  knn_pkg::cmd_t                  cmd,
  input  logic [STEP_W-1:0]              step,
  output knn_pkg::stat_t                 stat,
  output logic [knn_pkg::COORD_W-1:0]    out_col,
  output logic [knn_pkg::COORD_W-1:0]    out_row,
  output logic [knn_pkg::PIX_W-1:0]      filtered_value
);
  import knn_pkg::*;

  localparam int LINES = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
  localparam int NW    = MAX_WINDOW * MAX_WINDOW;
  localparam int CAP   = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;
  localparam int SLW   = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int YW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IW    = (NW > 1) ? $clog2(NW) : 1;
  localparam int RCW   = $clog2(NW + 1);
  localparam int CLW   = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = COORD_W + 1;
  localparam int AW    = $clog2(LINES * MAX_WIDTH);

  // configuration
  logic [N_W-1:0]   window_size;
  logic [K_W-1:0]   neighbor_count;
  logic [DIM_W-1:0] image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= RST_WINDOW_SIZE;
      neighbor_count <= RST_NEIGHBOR_COUNT;
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:    window_size    <= cfg_data[N_W-1:0];
        REG_NEIGHBOR_COUNT: neighbor_count <= cfg_data[K_W-1:0];
        REG_IMAGE_WIDTH:    image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [N_W-1:0] n_eff;
  logic [H_W-1:0] h;
  logic [K_W-1:0] k_eff;
  logic [WW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;
  logic [K_W-1:0] nsq;
  logic [N_W-1:0] n_odd;

  always_comb begin
    n_odd = window_size | N_W'(1);
    n_eff = (4'(n_odd) > 4'(CAP)) ? N_W'(CAP) : n_odd;
    h     = n_eff[N_W-1:1];
    nsq   = K_W'(n_eff) * K_W'(n_eff);
    k_eff = (neighbor_count == '0) ? K_W'(1) : neighbor_count;
    if (k_eff > nsq) k_eff = K_W'(n_eff);
    if (image_width == '0) w_eff = WW'(1);
    else if (32'(image_width) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(image_width);
    if (image_height == '0) h_eff = RW'(1);
    else if (image_height > DIM_W'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(image_height);
  end

  // position
  logic [CLW-1:0]     col_count, cur_c;
  logic [COORD_W-1:0] row_count;
  logic [SLW-1:0]     slot, cur_slot, rs;
  logic [PIX_W-1:0]   cur_pix;
  logic [WW-1:0]      c1, c2;
  logic [RW-1:0]      r1, r2;
  logic [SLW-1:0]     s1, s2;
  logic               interior;

  always_comb begin
    c1 = frame_start ? '0 : WW'(col_count);
    r1 = frame_start ? '0 : RW'(row_count);
    s1 = frame_start ? '0 : slot;
    if (c1 >= w_eff) begin
      c1 = '0;
      r1 = r1 + 1'b1;
      s1 = (s1 == SLW'(LINES - 1)) ? '0 : s1 + 1'b1;
    end
    if (r1 >= h_eff) begin
      r1 = '0;
      s1 = '0;
    end
    c2 = c1 + 1'b1;
    r2 = r1;
    s2 = s1;
    if (c2 >= w_eff) begin
      c2 = '0;
      r2 = r1 + 1'b1;
      s2 = (s1 == SLW'(LINES - 1)) ? '0 : s1 + 1'b1;
      if (r2 >= h_eff) begin
        r2 = '0;
        s2 = '0;
      end
    end
    interior = (c1 >= WW'({h, 1'b0})) && (r1 >= RW'({h, 1'b0}));
  end

  // line store
  logic [PIX_W-1:0] mem [LINES*MAX_WIDTH];
  logic [PIX_W-1:0] rdata;
  logic             rvalid_q;
  logic [YW-1:0]    ridx_q;
  logic [AW-1:0]    raddr, waddr;

  assign raddr = AW'(rs * MAX_WIDTH) + AW'(cur_c);
  assign waddr = AW'(cur_slot * MAX_WIDTH) + AW'(cur_c);

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata <= mem[raddr];
    if (cmd.wr) mem[waddr] <= cur_pix;
  end

  logic [COORD_W-1:0] pend_col, pend_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      slot      <= '0;
      stat      <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      rvalid_q <= cmd.rd;
      if (cmd.accept) begin
        col_count     <= CLW'(c2);
        row_count     <= r2[COORD_W-1:0];
        slot          <= s2;
        stat.interior <= interior;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_c    <= CLW'(c1);
      cur_slot <= s1;
      cur_pix  <= pixel_in;
      rs       <= (s1 == '0) ? SLW'(LINES - 1) : s1 - 1'b1;
      ridx_q   <= YW'(1);
      pend_col <= COORD_W'(c1 - WW'(h));
      pend_row <= COORD_W'(r1 - RW'(h));
    end else if (rvalid_q) begin
      ridx_q <= ridx_q + 1'b1;
    end
    if (cmd.rd) rs <= (rs == '0) ? SLW'(LINES - 1) : rs - 1'b1;
  end

  // window
  logic [PIX_W-1:0] win [MAX_WINDOW][MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int y = 0; y < MAX_WINDOW; y++)
        for (int x = MAX_WINDOW - 1; x > 0; x--)
          win[y][x] <= win[y][x-1];
      win[0][0] <= pixel_in;
    end else if (rvalid_q) begin
      win[ridx_q][0] <= rdata;
    end
  end

  // ranking: lane f holds column f / MAX_WINDOW, row f % MAX_WINDOW;
  // a higher lane comes earlier in scan order
  logic [PIX_W-1:0] lane_v [NW];
  logic [PIX_W-1:0] gap    [NW];
  logic [NW-1:0]    lane_ok, lane_q, mask;
  logic [PIX_W-1:0] centre;

  assign centre = win[YW'(h)][YW'(h)];

  for (genvar f = 0; f < NW; f++) begin : g_lane
    assign lane_v[f]  = win[f % MAX_WINDOW][f / MAX_WINDOW];
    assign lane_ok[f] = (4'(f % MAX_WINDOW) < 4'(n_eff)) &&
                        (4'(f / MAX_WINDOW) < 4'(n_eff));
  end

  logic [IW-1:0] idx;
  assign idx = step[IW-1:0];

  always_comb begin
    for (int j = 0; j < NW; j++)
      mask[j] = lane_q[j] && ((gap[j] < gap[idx]) ||
                ((gap[j] == gap[idx]) && (IW'(j) > idx)));
  end

  logic [NW-1:0]    mask_q;
  logic [PIX_W-1:0] vi_q;
  logic             vld_q, acc_q;
  logic [RCW-1:0]   rank_cnt;
  logic [SUM_W-1:0] sum;

  assign rank_cnt = RCW'($countones(mask_q));

  always_ff @(posedge clk) begin
    if (rst) acc_q <= 1'b0;
    else acc_q <= cmd.rank;
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      for (int j = 0; j < NW; j++) begin
        gap[j] <= (lane_v[j] > centre) ? lane_v[j] - centre : centre - lane_v[j];
      end
      lane_q <= lane_ok;
    end
    mask_q <= mask;
    vi_q   <= lane_v[idx];
    vld_q  <= lane_q[idx];
    if (cmd.diff) sum <= '0;
    else if (acc_q && vld_q && (rank_cnt < RCW'(k_eff))) sum <= sum + SUM_W'(vi_q);
  end

  // restoring divider, one quotient bit per cycle
  logic [NUM_W-1:0] dq;
  logic [REM_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [REM_W:0]   trial;

  assign den   = {k_eff, 1'b0};
  assign trial = {rem, dq[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq  <= NUM_W'({sum, 1'b0}) + NUM_W'(k_eff);
      rem <= '0;
    end else if (cmd.div_step) begin
      if (trial >= (REM_W+1)'(den)) begin
        rem <= REM_W'(trial - (REM_W+1)'(den));
        dq  <= {dq[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[REM_W-1:0];
        dq  <= {dq[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.load) begin
      out_col        <= pend_col;
      out_row        <= pend_row;
      filtered_value <= dq[PIX_W-1:0];
    end
  end

endmodule

// File: rtl/knn_gray_mean_filter.sv
// k-nearest gray mean filter.
// pix: one raster pixel per word, frame_start puts it at column 0, row 0.
// res: one word per interior pixel with its column, row and the rounded
//   mean of the K window values closest in gray level to the centre.
// cfg: register writes (index, data), always ready; write only when idle.
// Each pixel takes MAX_WINDOW-1 line store reads plus one write, which
// is all the work that a border pixel needs.
// An interior pixel then ranks all MAX_WINDOW^2 window lanes, one lane a
// cycle, and runs a restoring divide. The result then goes into the output
// register once that is free; the next pixel is taken while it waits
// there. If the output register is still full when the next result is
// ready, that result waits until it drains.
// Reset clears position, returns the registers to defaults and empties the
// output; line store contents stay undefined until written.
module knn_gray_mean_filter #(
  parameter int MAX_WINDOW = 7,
  parameter int MAX_WIDTH  = 1024
) (
  input logic    clk,
  input logic    rst,
  knn_pix_if.sink   pix,
  knn_res_if.source res,
  knn_cfg_if.sink   cfg
);
  import knn_pkg::*;

  localparam int NWT    = MAX_WINDOW * MAX_WINDOW;
  localparam int SMAX   = (NWT > NUM_W) ? NWT : NUM_W;
  localparam int STEP_W = $clog2(SMAX + 1);

  cmd_t              cmd;
  stat_t             stat;
  logic [STEP_W-1:0] step;

  assign cfg.ready = 1'b1;

  knn_ctrl #(.MAX_WINDOW(MAX_WINDOW), .STEP_W(STEP_W)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .stat      (stat),
    .cmd       (cmd),
    .step      (step)
  );

  knn_dp #(.MAX_WINDOW(MAX_WINDOW), .MAX_WIDTH(MAX_WIDTH), .STEP_W(STEP_W)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .pixel_in       (pix.pixel_in),
    .frame_start    (pix.frame_start),
    .cmd            (cmd),
    .step           (step),
    .stat           (stat),
    .out_col        (res.out_col),
    .out_row        (res.out_row),
    .filtered_value (res.filtered_value)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> !pix.ready)
    else $error("pixel taken while previous word still in work");

  a_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(!pix.ready))
    else $error("result appeared without a pixel in work");

  a_load_not_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !pix.ready)
    else $error("output loaded in idle");
`endif

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import knn_pkg::*;

  localparam int LINE_ROWS   = 6;
  localparam int LINE_LEN    = 1024;
  localparam int WIN         = 7;
  localparam int SETTLE      = 120;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   mean;
  } mean_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  knn_pix_if pix ();
  knn_res_if res ();
  knn_cfg_if cfg ();

  knn_gray_mean_filter dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  always #4 clk = ~clk;

  logic [PIX_W-1:0] line_mem [LINE_ROWS][LINE_LEN];
  logic [PIX_W-1:0] win_mem  [WIN][WIN];
  int               cur_col;
  int               cur_row;
  logic [N_W-1:0]   win_reg;
  logic [K_W-1:0]   k_reg;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  mean_word_t pending_means[$];
  int         fails      = 0;
  int         pixels_fed = 0;
  int         quiet      = 0;
  bit         send_gaps  = 1'b0;
  bit         recv_stall = 1'b0;

  // rounded mean of the k window values nearest in gray level to the centre
  function automatic logic [PIX_W-1:0] nearest_mean(int n, int k);
    int               h;
    int               taken;
    int               sum;
    int               gap;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] v;
    h      = n / 2;
    centre = win_mem[h][h];
    taken  = 0;
    sum    = 0;
    for (int d = 0; d < 256 && taken < k; d++) begin
      for (int ci = n - 1; ci >= 0; ci--) begin
        for (int ri = n - 1; ri >= 0; ri--) begin
          v   = win_mem[ri][ci];
          gap = (v > centre) ? v - centre : centre - v;
          if (gap == d && taken < k) begin
            sum += v;
            taken++;
          end
        end
      end
    end
    return PIX_W'((2 * sum + k) / (2 * k));
  endfunction

  function automatic void smooth_pixel(logic [PIX_W-1:0] p, logic fs);
    int         w;
    int         hg;
    int         n;
    int         h;
    int         k;
    int         c;
    int         r;
    int         slot;
    mean_word_t m;
    w  = (width_reg == 0) ? 1 : (width_reg > LINE_LEN ? LINE_LEN : width_reg);
    hg = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    n  = win_reg;
    if (n % 2 == 0) n++;
    if (n > WIN) n = WIN;
    h = n / 2;
    k = k_reg;
    if (fs) begin
      cur_col = 0;
      cur_row = 0;
    end
    c = cur_col;
    r = cur_row;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= hg) r = 0;
    for (int y = 0; y < WIN; y++)
      for (int x = WIN - 1; x > 0; x--)
        win_mem[y][x] = win_mem[y][x-1];
    win_mem[0][0] = p;
    slot = r % LINE_ROWS;
    for (int y = 1; y < WIN; y++)
      win_mem[y][0] = line_mem[(slot + LINE_ROWS - y) % LINE_ROWS][c];
    line_mem[slot][c] = p;
    if (k == 0) k = 1;
    if (k > n * n) k = n;
    if (c >= 2 * h && r >= 2 * h) begin
      m.col  = COORD_W'(c - h);
      m.row  = COORD_W'(r - h);
      m.mean = nearest_mean(n, k);
      pending_means.push_back(m);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= hg) r = 0;
    end
    cur_col = c;
    cur_row = r;
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p, input logic fs);
    if (send_gaps && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 13)) @(negedge clk);
    pix.valid       = 1'b1;
    pix.pixel_in    = p;
    pix.frame_start = fs;
    do @(posedge clk); while (!pix.ready);
    smooth_pixel(p, fs);
    pixels_fed++;
    @(negedge clk);
    pix.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_WINDOW_SIZE:    win_reg    = data[N_W-1:0];
      REG_NEIGHBOR_COUNT: k_reg      = data[K_W-1:0];
      REG_IMAGE_WIDTH:    width_reg  = data;
      REG_IMAGE_HEIGHT:   height_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_means.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_all(input logic [DIM_W-1:0] n, input logic [DIM_W-1:0] k,
                         input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] hg);
    drain();
    write_reg(REG_WINDOW_SIZE, n);
    write_reg(REG_NEIGHBOR_COUNT, k);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, hg);
  endtask

  // tie-heavy or full-range gray content
  function automatic logic [PIX_W-1:0] gray_sample(int mode, logic [PIX_W-1:0] base);
    case (mode)
      0: return PIX_W'($urandom_range(0, 255));
      1: return base + PIX_W'($urandom_range(0, 4));
      2: return $urandom_range(0, 1) ? 8'd0 : 8'd255;
      default: return base ^ PIX_W'(1 << $urandom_range(0, 7));
    endcase
  endfunction

  task automatic frame(input int w, input int hg, input int mode);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom_range(0, 255));
    for (int i = 0; i < w * hg; i++)
      send_pixel(gray_sample(mode, base), i == 0);
  endtask

  task automatic test_edge_values();
    set_all(3, 9, 4, 4);
    for (int i = 0; i < 16; i++)
      send_pixel((i % 2) ? 8'd255 : 8'd0, i == 0);
    set_all(2, 63, 3, 3);
    send_pixel(8'd10, 1'b1);
    send_pixel(8'd12, 1'b0);
    send_pixel(8'd8, 1'b0);
    send_pixel(8'd12, 1'b0);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd8, 1'b0);
    send_pixel(8'd9, 1'b0);
    send_pixel(8'd11, 1'b0);
    send_pixel(8'd10, 1'b0);
    set_all(11'h7F8, 0, 0, 0);
    send_pixel(8'd77, 1'b1);
    send_pixel(8'd255, 1'b0);
    set_all(7, 49, 7, 7);
    frame(7, 7, 0);
    set_all(6, 1, 2047, 2047);
    frame(3, 1, 2);
  endtask

  task automatic test_coord_limits();
    set_all(1, 1, 1024, 2);
    for (int i = 0; i < 1024; i++)
      send_pixel(PIX_W'($urandom_range(0, 255)), i == 0);
  endtask

  task automatic test_random_frames(input int target);
    int w;
    int hg;
    int n;
    target += pixels_fed;
    while (pixels_fed < target) begin
      n  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 4);
      w  = $urandom_range(1, 20);
      hg = $urandom_range(1, 10);
      if ($urandom_range(0, 15) == 0) w = $urandom_range(1025, 2047);
      set_all(DIM_W'(n), DIM_W'($urandom_range(0, 63)), DIM_W'(w), DIM_W'(hg));
      send_gaps  = $urandom_range(0, 3) != 0;
      recv_stall = $urandom_range(0, 3) != 0;
      if (w > LINE_LEN) w = $urandom_range(1, 30);
      repeat ($urandom_range(1, 3)) begin
        frame(w, hg, $urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 8))
            send_pixel(PIX_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      end
    end
  endtask

  task automatic test_no_idle();
    set_all(5, 13, 9, 7);
    send_gaps  = 1'b0;
    recv_stall = 1'b0;
    frame(9, 7, 1);
    frame(9, 7, 0);
  endtask

  initial begin
    pix.valid       = 1'b0;
    pix.pixel_in    = '0;
    pix.frame_start = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    win_reg    = RST_WINDOW_SIZE;
    k_reg      = RST_NEIGHBOR_COUNT;
    width_reg  = RST_IMAGE_WIDTH;
    height_reg = RST_IMAGE_HEIGHT;
    cur_col    = 0;
    cur_row    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_gaps  = 1'b1;
    recv_stall = 1'b1;
    test_edge_values();
    test_coord_limits();
    test_random_frames(720);
    test_no_idle();
    drain();
    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    res.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (recv_stall && $urandom_range(0, 4) == 0) begin
        res.ready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end else begin
        res.ready = 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    mean_word_t m;
    if (!rst && res.valid && res.ready) begin
      if (pending_means.size() == 0) begin
        $error("unexpected word: col %0d row %0d value %0d",
               res.out_col, res.out_row, res.filtered_value);
        fails++;
      end else begin
        m = pending_means.pop_front();
        if (res.out_col !== m.col) begin
          $error("out_col: expected %0d, got %0d", m.col, res.out_col);
          fails++;
        end
        if (res.out_row !== m.row) begin
          $error("out_row: expected %0d, got %0d", m.row, res.out_row);
          fails++;
        end
        if (res.filtered_value !== m.mean) begin
          $error("filtered_value: expected %0d, got %0d", m.mean, res.filtered_value);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
